>>> sv/cvh_pkg.sv
// shared types for the gift-wrap convex hull block
// no dependencies; imported by cvh_front, cvh_back and the top level
package cvh_pkg;

    // control bits of one queued beat
    typedef struct packed {
        logic store;    // point goes into the point memory
        logic last;     // set closes here, run the hull walk
        logic ovf;      // some point of this set was dropped
    } t_q_ctl;

    localparam int CTL_W = $bits(t_q_ctl);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIN,
        S_CHECK,
        S_RD,
        S_DIFF,
        S_MUL,
        S_SUM,
        S_DEC,
        S_NEXT
    } t_back_state;

endpackage

>>> sv/cvh_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cvh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/cvh_queue.sv
// two-entry queue between the front and back parts
// no dependencies
module cvh_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> sv/cvh_front.sv
// front part: takes point beats, assigns store slots, flags overflow
// depends on cvh_pkg; feeds cvh_queue
module cvh_front
    import cvh_pkg::*;
#(
    parameter int CW         = 16,
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [CW-1:0]        i_x,
    input  logic [CW-1:0]        i_y,
    input  logic                 i_last,
    input  logic                 i_q_full,
    input  logic                 i_done,
    output logic                 o_push,
    output logic [2*CW+$clog2(MAX_POINTS)+$clog2(MAX_POINTS+1)+CTL_W-1:0] o_push_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    logic [NW-1:0] r_count;
    logic          r_ovf;
    logic          r_run_pend;
    logic          n_run_pend;
    logic          accept;
    logic          can_store;
    logic [NW-1:0] n_count;
    logic          n_ovf;
    t_q_ctl        ctl;

    assign o_busy    = r_run_pend || i_q_full;
    assign accept    = i_start && !o_busy;
    assign can_store = (r_count < NW'(MAX_POINTS));
    assign n_count   = can_store ? r_count + NW'(1) : r_count;
    assign n_ovf     = r_ovf || !can_store;

    always_comb begin
        ctl.store = can_store;
        ctl.last  = i_last;
        ctl.ovf   = n_ovf;
    end

    assign o_push      = accept;
    assign o_push_data = {i_x, i_y, r_count[AW-1:0], n_count, ctl};

    always_comb begin
        n_run_pend = r_run_pend;
        if (i_done) begin
            n_run_pend = 1'b0;
        end
        if (accept && i_last) begin
            n_run_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_run_pend <= 1'b0;
        end else begin
            r_run_pend <= n_run_pend;
            if (accept) begin
                // a closing beat starts the next set from empty
                r_count <= i_last ? '0 : n_count;
                r_ovf   <= i_last ? 1'b0 : n_ovf;
            end
        end
    end

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> o_busy)
        else $error("front accepted a closing beat but did not go busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_POINTS))
        else $error("point count beyond capacity");

endmodule

>>> sv/cvh_back.sv
// back part: writes points into memory and runs the gift-wrap walk
// depends on cvh_pkg and cvh_ram; fed by cvh_queue
module cvh_back
    import cvh_pkg::*;
#(
    parameter int CW         = 16,
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  logic [2*CW+$clog2(MAX_POINTS)+$clog2(MAX_POINTS+1)+CTL_W-1:0] i_q_data,
    output logic                 o_pop,
    output logic                 o_done,
    output logic                 o_vld,
    output logic [CW-1:0]        o_x,
    output logic [CW-1:0]        o_y,
    output logic                 o_last,
    output logic                 o_dropped
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int DW = CW + 1;         // coordinate difference
    localparam int PW = 2 * DW;         // one product
    localparam int SW = PW + 1;         // cross product or squared distance

    t_back_state r_state;
    t_back_state n_state;

    // queue beat fields
    logic [CW-1:0] q_x;
    logic [CW-1:0] q_y;
    logic [AW-1:0] q_addr;
    logic [NW-1:0] q_n;
    t_q_ctl        q_ctl;

    assign {q_x, q_y, q_addr, q_n, q_ctl} = i_q_data;

    // memory
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [2*CW-1:0]   ram_rdata;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;

    cvh_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (q_addr),
        .i_wdata ({q_x, q_y}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign px = ram_rdata[2*CW-1:CW];
    assign py = ram_rdata[CW-1:0];

    // set info
    logic [NW-1:0] r_n;
    logic          r_ovf;
    logic [AW-1:0] n_m1;

    assign n_m1 = AW'(r_n - NW'(1));

    // min search
    logic [NW-1:0]        r_rd_idx;
    logic                 r_rd_vld;
    logic                 r_rd_first;
    logic signed [CW-1:0] r_sx;
    logic signed [CW-1:0] r_sy;
    logic                 min_take;
    logic                 min_issue;

    assign min_issue = (r_rd_idx != r_n);
    assign min_take  = r_rd_first || (px < r_sx) || ((px == r_sx) && (py < r_sy));

    // walk
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic [NW-1:0]        r_k;
    logic [AW-1:0]        r_i;
    logic signed [CW-1:0] r_px;
    logic signed [CW-1:0] r_py;
    logic signed [DW-1:0] r_d2x;
    logic signed [DW-1:0] r_d2y;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic signed [PW-1:0] r_q1;
    logic signed [PW-1:0] r_q2;
    logic signed [SW-1:0] r_cross;
    logic signed [SW-1:0] r_dist;
    logic signed [CW-1:0] r_nx;
    logic signed [CW-1:0] r_ny;
    logic signed [DW-1:0] r_d1x;
    logic signed [DW-1:0] r_d1y;
    logic signed [SW-1:0] r_cand_dist;
    logic signed [DW-1:0] d2x;
    logic signed [DW-1:0] d2y;
    logic                 take;
    logic                 at_bound;
    logic                 back_home;

    assign d2x       = {px[CW-1], px} - {r_cx[CW-1], r_cx};
    assign d2y       = {py[CW-1], py} - {r_cy[CW-1], r_cy};
    assign at_bound  = (r_k == NW'(MAX_POINTS));
    assign back_home = (r_nx == r_sx) && (r_ny == r_sy);

    always_comb begin
        priority if (r_i == '0) begin
            take = 1'b1;                      // entry 0 seeds the candidate
        end else if (r_cross == '0) begin
            take = (r_dist > r_cand_dist);    // collinear: keep the farther one
        end else begin
            take = !r_cross[SW-1];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty && q_ctl.last) begin
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (!min_issue && !r_rd_vld) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = at_bound ? S_IDLE : S_RD;
            S_RD:    n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_DEC;
            S_DEC:   n_state = (r_i == n_m1) ? S_NEXT : S_RD;
            S_NEXT:  n_state = back_home ? S_IDLE : S_CHECK;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic emit;
    logic emit_last;

    always_comb begin
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = r_i;
        emit      = 1'b0;
        emit_last = 1'b0;
        o_done    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop  = !i_q_empty;
                ram_we = !i_q_empty && q_ctl.store;
            end
            S_MIN: begin
                ram_raddr = r_rd_idx[AW-1:0];
            end
            S_CHECK: begin
                emit      = at_bound;
                emit_last = at_bound;
                o_done    = at_bound;
            end
            S_NEXT: begin
                // the pending vertex goes out once its successor is known
                emit      = 1'b1;
                emit_last = back_home;
                o_done    = back_home;
            end
            default: begin
                ram_raddr = r_i;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            o_vld   <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_x       <= r_cx;
            o_y       <= r_cy;
            o_last    <= emit_last;
            o_dropped <= r_ovf;
        end

        unique case (r_state)
            S_IDLE: begin
                r_n        <= q_n;
                r_ovf      <= q_ctl.ovf;
                r_rd_idx   <= '0;
                r_rd_vld   <= 1'b0;
                r_rd_first <= 1'b0;
            end
            S_MIN: begin
                r_rd_vld   <= min_issue;
                r_rd_first <= (r_rd_idx == '0);
                if (min_issue) begin
                    r_rd_idx <= r_rd_idx + NW'(1);
                end
                if (r_rd_vld && min_take) begin
                    r_sx <= px;
                    r_sy <= py;
                end
                r_cx <= r_sx;
                r_cy <= r_sy;
                r_k  <= NW'(1);
            end
            S_CHECK: begin
                r_i <= '0;
            end
            S_DIFF: begin
                r_px  <= px;
                r_py  <= py;
                r_d2x <= d2x;
                r_d2y <= d2y;
            end
            S_MUL: begin
                r_p1 <= r_d1x * r_d2y;
                r_p2 <= r_d1y * r_d2x;
                r_q1 <= r_d2x * r_d2x;
                r_q2 <= r_d2y * r_d2y;
            end
            S_SUM: begin
                r_cross <= SW'(r_p1) - SW'(r_p2);
                r_dist  <= SW'(r_q1) + SW'(r_q2);
            end
            S_DEC: begin
                if (take) begin
                    r_nx        <= r_px;
                    r_ny        <= r_py;
                    r_d1x       <= r_d2x;
                    r_d1y       <= r_d2y;
                    r_cand_dist <= r_dist;
                end
                r_i <= r_i + AW'(1);
            end
            S_NEXT: begin
                r_cx <= r_nx;
                r_cy <= r_ny;
                r_k  <= r_k + NW'(1);
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> ($past(r_state) == S_CHECK || $past(r_state) == S_NEXT))
        else $error("result beat outside a vertex decision");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> (r_i <= n_m1))
        else $error("walk scan index beyond stored points");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK || r_state == S_NEXT) |-> (r_k <= NW'(MAX_POINTS)))
        else $error("hull vertex count beyond capacity");

endmodule

>>> sv/convex_hull_gift_wrap.sv
// top level of the gift-wrap convex hull block
// depends on cvh_pkg, cvh_front, cvh_queue, cvh_back (cvh_ram inside cvh_back)
//
// channel   direction  handshake                 payload
// point     in         start && !busy            i_point_x, i_point_y, i_last_point
// vertex    out        o_hull_valid, one cycle   o_hull_x, o_hull_y, o_hull_last,
//                                                o_points_dropped
//
// while busy is low, points load one beat per cycle into the point memory through a
// two-entry queue; after the closing beat the queue drains, the leftmost-point search
// runs, then each hull vertex costs a five-step scan per stored point (read, difference,
// multiply, sum, decide), bound by the memory read and the cross-product multipliers
// busy stays high from the closing beat until the final vertex strobe appears
// synchronous active-low reset clears control only; the point memory is not cleared
// the vertex output cannot be stalled
module convex_hull_gift_wrap
    import cvh_pkg::*;
#(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    input  logic                   i_last_point,
    output logic                   o_hull_valid,
    output logic [COORD_WIDTH-1:0] o_hull_x,
    output logic [COORD_WIDTH-1:0] o_hull_y,
    output logic                   o_hull_last,
    output logic                   o_points_dropped
);

    localparam int QW = 2 * COORD_WIDTH + $clog2(MAX_POINTS) + $clog2(MAX_POINTS + 1)
                        + CTL_W;

    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    logic          done;
    logic [QW-1:0] push_data;
    logic [QW-1:0] pop_data;

    cvh_front #(
        .CW         (COORD_WIDTH),
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_x         (i_point_x),
        .i_y         (i_point_y),
        .i_last      (i_last_point),
        .i_q_full    (q_full),
        .i_done      (done),
        .o_push      (push),
        .o_push_data (push_data)
    );

    cvh_queue #(
        .DW (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (pop_data)
    );

    cvh_back #(
        .CW         (COORD_WIDTH),
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (pop_data),
        .o_pop     (pop),
        .o_done    (done),
        .o_vld     (o_hull_valid),
        .o_x       (o_hull_x),
        .o_y       (o_hull_y),
        .o_last    (o_hull_last),
        .o_dropped (o_points_dropped)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// testbench for convex_hull_gift_wrap: point sets are sent one beat at a time and every
// hull vertex strobe is checked against a gift-wrap walk of the same set kept in the bench
// depends on cvh_pkg and the convex_hull_gift_wrap RTL; reads no files
module tb;

    localparam int COORD_W       = 16;
    localparam int MAX_PTS       = 64;
    localparam int STALL_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 400;
    localparam int PHASE_POINTS  = 32;
    localparam int MAX_PRINTS    = 40;
    localparam int IDLE_LOW_PCT  = 32;
    localparam int IDLE_HIGH_PCT = 54;
    localparam int DIRECTED_ROWS = 24;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic               dropped;
    } hull_vertex_t;

    // typed = the set closes here and its hull is this point alone
    typedef struct {
        int x;
        int y;
        bit last;
        bit typed;
    } point_row_t;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_TINY,
        SPREAD_MID,
        SPREAD_EDGE
    } coord_spread_t;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               start            = 1'b0;
    logic               busy;
    logic [COORD_W-1:0] i_point_x        = '0;
    logic [COORD_W-1:0] i_point_y        = '0;
    logic               i_last_point     = 1'b0;
    logic               o_hull_valid;
    logic [COORD_W-1:0] o_hull_x;
    logic [COORD_W-1:0] o_hull_y;
    logic               o_hull_last;
    logic               o_points_dropped;

    // point set as the block should hold it
    longint       set_x [MAX_PTS];
    longint       set_y [MAX_PTS];
    int           set_count     = 0;
    bit           set_overflow  = 1'b0;

    hull_vertex_t walk_out [$];
    hull_vertex_t hull_expected [$];
    logic         row_typed     = 1'b0;
    int           sender_idle_pct = IDLE_LOW_PCT;

    int mismatches    = 0;
    int points_in     = 0;
    int sets_closed   = 0;
    int overflow_sets = 0;
    int vertices_seen = 0;
    int stall_cycles  = 0;

    point_row_t directed_rows [DIRECTED_ROWS] = '{
        '{-32768, -32768, 1'b1, 1'b1},
        '{ 32767,  32767, 1'b1, 1'b1},
        '{     5,      5, 1'b0, 1'b0},
        '{     5,      5, 1'b0, 1'b0},
        '{     5,      5, 1'b1, 1'b1},
        '{-32768,  32767, 1'b0, 1'b0},
        '{ 32767, -32768, 1'b0, 1'b0},
        '{ 32767,  32767, 1'b0, 1'b0},
        '{-32768, -32768, 1'b0, 1'b0},
        '{     0,      0, 1'b1, 1'b0},
        '{     3,      3, 1'b0, 1'b0},
        '{     0,      0, 1'b0, 1'b0},
        '{     2,      2, 1'b0, 1'b0},
        '{     1,      1, 1'b1, 1'b0},
        '{-32768,      0, 1'b0, 1'b0},
        '{ 32767,      0, 1'b0, 1'b0},
        '{     0,      0, 1'b1, 1'b0},
        '{     0,      0, 1'b0, 1'b0},
        '{     4,      0, 1'b0, 1'b0},
        '{     4,      4, 1'b0, 1'b0},
        '{     0,      4, 1'b0, 1'b0},
        '{     2,      2, 1'b0, 1'b0},
        '{     4,      4, 1'b0, 1'b0},
        '{     0,      2, 1'b1, 1'b0}
    };

    convex_hull_gift_wrap #(
        .MAX_POINTS  (MAX_PTS),
        .COORD_WIDTH (COORD_W)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_last_point     (i_last_point),
        .o_hull_valid     (o_hull_valid),
        .o_hull_x         (o_hull_x),
        .o_hull_y         (o_hull_y),
        .o_hull_last      (o_hull_last),
        .o_points_dropped (o_points_dropped)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // stores one point and, on the closing point, leaves the hull vertices in walk_out
    task automatic wrap_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py, input logic lp);
        int           n;
        int           first;
        longint       cx, cy, nx, ny, d1x, d1y, d2x, d2y, cr;
        bit           take;
        hull_vertex_t v;
        walk_out.delete();
        if (set_count < MAX_PTS) begin
            set_x[set_count] = px;
            set_y[set_count] = py;
            set_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (!lp) return;

        n = set_count;
        first = 0;
        for (int i = 1; i < n; i++) begin
            if (set_x[i] < set_x[first] ||
                (set_x[i] == set_x[first] && set_y[i] < set_y[first])) begin
                first = i;
            end
        end
        cx = set_x[first];
        cy = set_y[first];
        v.x = cx[COORD_W-1:0];
        v.y = cy[COORD_W-1:0];
        v.last = 1'b0;
        v.dropped = set_overflow;
        walk_out.insert(walk_out.size(), v);

        while (walk_out.size() < MAX_PTS) begin
            nx = set_x[0];
            ny = set_y[0];
            for (int i = 1; i < n; i++) begin
                d1x = nx - cx;
                d1y = ny - cy;
                d2x = set_x[i] - cx;
                d2y = set_y[i] - cy;
                cr = d1x * d2y - d1y * d2x;
                // collinear: keep the farther point
                if (cr == 0) take = (d1x * d1x + d1y * d1y) < (d2x * d2x + d2y * d2y);
                else take = cr > 0;
                if (take) begin
                    nx = set_x[i];
                    ny = set_y[i];
                end
            end
            if (nx == set_x[first] && ny == set_y[first]) break;
            v.x = nx[COORD_W-1:0];
            v.y = ny[COORD_W-1:0];
            walk_out.insert(walk_out.size(), v);
            cx = nx;
            cy = ny;
        end
        walk_out[walk_out.size()-1].last = 1'b1;

        sets_closed++;
        if (set_overflow) overflow_sets++;
        set_count = 0;
        set_overflow = 1'b0;
    endtask

    always @(posedge i_clk) begin : monitor
        hull_vertex_t want;
        hull_vertex_t typed_vertex;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_hull_valid) begin
                moved = 1'b1;
                vertices_seen++;
                if (hull_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected vertex x=%0d y=%0d",
                                              $signed(o_hull_x), $signed(o_hull_y)));
                end else begin
                    want = hull_expected.pop_front();
                    if (o_hull_x !== want.x || o_hull_y !== want.y ||
                        o_hull_last !== want.last || o_points_dropped !== want.dropped) begin
                        report_mismatch($sformatf(
                            "vertex %0d got (%0d,%0d) l=%b d=%b want (%0d,%0d) l=%b d=%b",
                            vertices_seen, $signed(o_hull_x), $signed(o_hull_y), o_hull_last,
                            o_points_dropped, $signed(want.x), $signed(want.y), want.last,
                            want.dropped));
                    end
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                points_in++;
                wrap_point(i_point_x, i_point_y, i_last_point);
                if (row_typed) begin
                    typed_vertex.x = i_point_x;
                    typed_vertex.y = i_point_y;
                    typed_vertex.last = 1'b1;
                    typed_vertex.dropped = 1'b0;
                    hull_expected.insert(hull_expected.size(), typed_vertex);
                end else begin
                    foreach (walk_out[i]) hull_expected.insert(hull_expected.size(), walk_out[i]);
                end
            end
        end
        stall_cycles <= moved ? 0 : stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("no beat moved for %0d cycles, %0d vertices outstanding",
                 STALL_LIMIT, hull_expected.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic drive_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                               input logic lp, input logic typed);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_point_x    <= px;
        i_point_y    <= py;
        i_last_point <= lp;
        row_typed    <= typed;
        do @(posedge i_clk); while (busy);
    endtask

    // hold off until every vertex of the closed sets has come out
    task automatic drain_hull();
        start <= 1'b0;
        do @(posedge i_clk); while (hull_expected.size() != 0);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(input coord_spread_t spread);
        int r;
        case (spread)
            SPREAD_FULL: r = int'($urandom_range(65535)) - 32768;
            SPREAD_TINY: r = int'($urandom_range(8)) - 4;
            SPREAD_MID:  r = int'($urandom_range(600)) - 300;
            default:     r = $urandom_range(1) ? 32767 - int'($urandom_range(3))
                                               : -32768 + int'($urandom_range(3));
        endcase
        return COORD_W'(r);
    endfunction

    task automatic send_random_set(inout int sent);
        int            n;
        coord_spread_t spread;
        n = ($urandom_range(9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
        spread = coord_spread_t'($urandom_range(3));
        for (int i = 0; i < n; i++) begin
            drive_point(rand_coord(spread), rand_coord(spread), i == n - 1, 1'b0);
        end
        sent += n;
    endtask

    initial begin : stimulus
        int sent;
        int rot;
        int j;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = IDLE_LOW_PCT;
        foreach (directed_rows[i]) begin
            drive_point(COORD_W'(directed_rows[i].x), COORD_W'(directed_rows[i].y),
                        directed_rows[i].last, directed_rows[i].typed);
        end
        drain_hull();

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? IDLE_LOW_PCT : (phase == 1) ? IDLE_HIGH_PCT : 0;
            sent = 0;
            if (phase == 1) begin
                // full store of points on a parabola: every point is a hull vertex, so the
                // walk hits its length bound; two more points overflow, the closing one too
                rot = $urandom_range(MAX_PTS - 1);
                for (int i = 0; i < MAX_PTS; i++) begin
                    j = (i + rot) % MAX_PTS;
                    drive_point(COORD_W'(j * 1024 - 32768),
                                COORD_W'((j - 32) * (j - 32) * 31 - 32768), 1'b0, 1'b0);
                end
                drive_point(rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL), 1'b0, 1'b0);
                drive_point(rand_coord(SPREAD_EDGE), rand_coord(SPREAD_EDGE), 1'b1, 1'b0);
                sent += MAX_PTS + 2;
            end
            while (sent < PHASE_POINTS) send_random_set(sent);
        end

        drain_hull();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d points in %0d sets, %0d of them overflowing the store",
                 points_in, sets_closed, overflow_sets);
        $display("checked %0d hull vertices, %0d mismatches", vertices_seen, mismatches);
        if (mismatches == 0 && hull_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
